### src/cblp_pkg.sv
// ----------------------------------------------------------------------------
// cblp_pkg
// Shared types, codes and constants of the serial bridge link parser.
// ----------------------------------------------------------------------------
package cblp_pkg;

    // protocol constants
    localparam logic [7:0]  MARK          = 8'hF1;
    localparam logic [7:0]  SYNC_BYTE     = 8'hE7;
    localparam logic [7:0]  CMD_FRAME     = 8'd0;
    localparam logic [7:0]  CMD_TSYNC     = 8'd1;
    localparam logic [7:0]  CMD_SETUP     = 8'd5;
    localparam logic [7:0]  CMD_PARAMS    = 8'd6;
    localparam logic [7:0]  CMD_INFO      = 8'd7;
    localparam logic [7:0]  CMD_VALIDATE  = 8'd9;
    localparam logic [7:0]  CMD_NBUS      = 8'd12;
    localparam logic [7:0]  CMD_EXTBUS    = 8'd13;
    localparam int          MAX_PAYLOAD   = 8;
    localparam logic [31:0] RATE_FLAGS    = 32'hC000_0000;
    localparam logic [31:0] RESET_BAUD    = 32'd500000;
    localparam logic [7:0]  RESET_RELOAD  = 8'd10;
    localparam logic [4:0]  TSYNC_LEN     = 5'd4;
    localparam logic [4:0]  EXTBUS_LEN    = 5'd15;
    localparam int          QUEUE_DEPTH   = 2;

    // input commands
    localparam logic [1:0] IN_RX      = 2'd0;
    localparam logic [1:0] IN_BEAT    = 2'd1;
    localparam logic [1:0] IN_START   = 2'd2;
    localparam logic [1:0] IN_TIMEOUT = 2'd3;

    // configuration register indexes
    localparam logic CFG_FALLBACK_BAUD = 1'b0;
    localparam logic CFG_HB_RELOAD     = 1'b1;

    // event kinds
    localparam logic [2:0] EV_FRAME  = 3'd0;
    localparam logic [2:0] EV_PARAMS = 3'd1;
    localparam logic [2:0] EV_INFO   = 3'd2;
    localparam logic [2:0] EV_TX     = 3'd3;
    localparam logic [2:0] EV_CONN   = 3'd4;
    localparam logic [2:0] EV_DISC   = 3'd5;

    typedef enum logic [2:0] {
        PS_IDLE, PS_CMD, PS_FRAME, PS_TSYNC, PS_PARAMS, PS_INFO, PS_NBUS, PS_EXTBUS
    } parse_state_t;

    typedef enum logic [2:0] {
        JOB_FRAME, JOB_PARAMS, JOB_INFO, JOB_NBUS, JOB_HEART, JOB_DISC, JOB_HAND
    } job_kind_t;

    // one classified piece of work between front and back
    typedef struct packed {
        job_kind_t   kind;
        logic [31:0] stamp;
        logic [30:0] ident;
        logic        ext;
        logic [3:0]  bus;
        logic [3:0]  len;
        logic [63:0] payload;
        logic [31:0] word_a;
        logic [31:0] word_b;
        logic [1:0]  enables;
        logic [31:0] setup_word;
        logic        conn;
    } job_t;

    // session start handshake bytes
    function automatic logic [7:0] hand_byte(input logic [3:0] i);
        logic [7:0] b;
        case (i)
            4'd0, 4'd1: b = SYNC_BYTE;
            4'd3:       b = CMD_NBUS;
            4'd5:       b = CMD_PARAMS;
            4'd7:       b = CMD_INFO;
            4'd9:       b = 8'd1;
            4'd11:      b = CMD_VALIDATE;
            default:    b = MARK;
        endcase
        return b;
    endfunction

endpackage

### src/cblp_front.sv
// ----------------------------------------------------------------------------
// cblp_front
// Accepts commands and received bytes, runs the deframer and link state,
// and posts one job per word-producing item to the queue.
// ----------------------------------------------------------------------------
module cblp_front
    import cblp_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_ready,
    input  logic [1:0]  command,
    input  logic [7:0]  rx_byte,
    input  logic        cfg_we,
    input  logic        cfg_index,
    input  logic [31:0] cfg_data,
    input  logic        q_full,
    output logic        push,
    output job_t        push_job
);

    parse_state_t state_reg, state_next;
    logic [4:0]  step_reg, step_next;
    logic [31:0] stamp_reg, stamp_next;
    logic [30:0] ident_reg, ident_next;
    logic [31:0] ident_raw_reg, ident_raw_next;
    logic        ext_reg, ext_next;
    logic [3:0]  fbus_reg, fbus_next;
    logic [3:0]  flen_reg, flen_next;
    logic [7:0]  bytes_reg [8];
    logic [7:0]  bytes_next [8];
    logic [31:0] bus0_reg, bus0_next;
    logic [31:0] bus1_reg, bus1_next;
    logic [1:0]  en_reg, en_next;
    logic [15:0] build_reg, build_next;
    logic [7:0]  hb_left_reg, hb_left_next;
    logic        awaiting_reg, awaiting_next;
    logic        up_reg, up_next;
    logic        open_reg, open_next;
    logic [31:0] baud_reg;
    logic [7:0]  reload_reg;
    logic        accept;
    logic        job_valid;
    job_t        job;

    assign in_ready = !q_full;
    assign accept   = in_valid && in_ready;
    assign push     = accept && job_valid;
    assign push_job = job;

    // deframer and link state
    always_comb
    begin
        logic [4:0]  idx;
        logic [3:0]  dlc;
        logic [31:0] wide;
        logic [4:0]  sh;
        logic [63:0] pl;
        state_next     = state_reg;
        step_next      = step_reg;
        stamp_next     = stamp_reg;
        ident_next     = ident_reg;
        ident_raw_next = ident_raw_reg;
        ext_next       = ext_reg;
        fbus_next      = fbus_reg;
        flen_next      = flen_reg;
        bytes_next     = bytes_reg;
        bus0_next      = bus0_reg;
        bus1_next      = bus1_reg;
        en_next        = en_reg;
        build_next     = build_reg;
        hb_left_next   = hb_left_reg;
        awaiting_next  = awaiting_reg;
        up_next        = up_reg;
        open_next      = open_reg;
        job_valid      = 1'b0;
        job            = '0;
        idx            = step_reg - 5'd9;
        dlc            = rx_byte[3:0];
        wide           = {24'd0, rx_byte};
        sh             = {step_reg[1:0], 3'b000};
        pl             = '0;
        case (command)
            IN_RX:
            begin
                if (open_reg)
                begin
                    case (state_reg)
                        PS_IDLE:
                        begin
                            if (rx_byte == MARK)
                                state_next = PS_CMD;
                        end
                        PS_CMD:
                        begin
                            step_next = '0;
                            case (rx_byte)
                                CMD_FRAME:    state_next = PS_FRAME;
                                CMD_TSYNC:    state_next = PS_TSYNC;
                                CMD_PARAMS:   state_next = PS_PARAMS;
                                CMD_INFO:     state_next = PS_INFO;
                                CMD_VALIDATE:
                                begin
                                    hb_left_next  = reload_reg;
                                    awaiting_next = 1'b0;
                                    state_next    = PS_IDLE;
                                end
                                CMD_NBUS:     state_next = PS_NBUS;
                                CMD_EXTBUS:   state_next = PS_EXTBUS;
                                default:      state_next = PS_IDLE;
                            endcase
                        end
                        PS_FRAME:
                        begin
                            step_next = step_reg + 5'd1;
                            if (step_reg < 5'd4)
                            begin
                                stamp_next = (step_reg == 5'd0) ? wide
                                                                : (stamp_reg | (wide << sh));
                            end
                            else if (step_reg < 5'd8)
                            begin
                                ident_raw_next = (step_reg == 5'd4) ? wide
                                                 : (ident_raw_reg | (wide << sh));
                                if (step_reg == 5'd7)
                                begin
                                    ext_next   = ident_raw_next[31];
                                    ident_next = ident_raw_next[30:0];
                                end
                            end
                            else if (step_reg == 5'd8)
                            begin
                                fbus_next = rx_byte[7:4];
                                if (dlc > 4'(MAX_PAYLOAD))
                                    state_next = PS_IDLE;
                                else
                                begin
                                    flen_next = dlc;
                                    for (int i = 0; i < 8; i++)
                                        bytes_next[i] = '0;
                                    if (dlc == 4'd0)
                                    begin
                                        job_valid  = 1'b1;
                                        state_next = PS_IDLE;
                                    end
                                end
                            end
                            else if (idx < {1'b0, flen_reg} && idx < 5'd8)
                            begin
                                bytes_next[idx[2:0]] = rx_byte;
                                if (idx + 5'd1 == {1'b0, flen_reg})
                                begin
                                    job_valid  = 1'b1;
                                    state_next = PS_IDLE;
                                end
                            end
                            else
                                state_next = PS_IDLE;
                            // frame word from the updated shadow
                            for (int i = 0; i < 8; i++)
                                if (4'(i) < flen_next)
                                    pl[8*i +: 8] = bytes_next[i];
                            job.kind    = JOB_FRAME;
                            job.stamp   = stamp_reg;
                            job.ident   = ident_reg;
                            job.ext     = ext_reg;
                            job.bus     = fbus_next;
                            job.len     = flen_next;
                            job.payload = pl;
                        end
                        PS_TSYNC:
                        begin
                            step_next = step_reg + 5'd1;
                            if (step_next >= TSYNC_LEN)
                                state_next = PS_IDLE;
                        end
                        PS_PARAMS:
                        begin
                            step_next = step_reg + 5'd1;
                            case (step_reg)
                                5'd0: en_next[0] = (rx_byte[3:0] != 4'd0);
                                5'd1: bus0_next = wide;
                                5'd2: bus0_next = bus0_reg | (wide << 8);
                                5'd3: bus0_next = bus0_reg | (wide << 16);
                                5'd4: bus0_next = bus0_reg | (wide << 24);
                                5'd5: en_next[1] = (rx_byte[3:0] != 4'd0);
                                5'd6: bus1_next = wide;
                                5'd7: bus1_next = bus1_reg | (wide << 8);
                                5'd8: bus1_next = bus1_reg | (wide << 16);
                                default:
                                begin
                                    bus1_next      = bus1_reg | (wide << 24);
                                    job_valid      = 1'b1;
                                    job.kind       = JOB_PARAMS;
                                    job.word_a     = bus0_reg;
                                    job.word_b     = bus1_next;
                                    job.enables    = en_reg;
                                    job.setup_word = ((bus0_reg != '0) ? bus0_reg : baud_reg)
                                                     | RATE_FLAGS;
                                    job.conn       = !up_reg;
                                    up_next        = 1'b1;
                                    state_next     = PS_IDLE;
                                end
                            endcase
                        end
                        PS_INFO:
                        begin
                            step_next = step_reg + 5'd1;
                            if (step_reg == 5'd0)
                                build_next = {8'd0, rx_byte};
                            else if (step_reg == 5'd1)
                                build_next = build_reg | {rx_byte, 8'd0};
                            else if (step_reg >= 5'd5)
                            begin
                                job_valid   = 1'b1;
                                job.kind    = JOB_INFO;
                                job.word_a  = {16'd0, build_reg};
                                job.word_b  = wide;
                                state_next  = PS_IDLE;
                            end
                        end
                        PS_NBUS:
                        begin
                            job_valid  = 1'b1;
                            job.kind   = JOB_NBUS;
                            state_next = PS_IDLE;
                        end
                        default:
                        begin
                            step_next = step_reg + 5'd1;
                            if (step_next >= EXTBUS_LEN)
                                state_next = PS_IDLE;
                        end
                    endcase
                end
            end
            IN_BEAT:
            begin
                if (open_reg && up_reg)
                begin
                    job_valid = 1'b1;
                    job.kind  = JOB_HEART;
                    if (!awaiting_reg)
                    begin
                        if (hb_left_reg != 8'd0)
                            hb_left_next = hb_left_reg - 8'd1;
                        if (hb_left_reg <= 8'd1)
                        begin
                            open_next = 1'b0;
                            job.kind  = JOB_DISC;
                        end
                    end
                end
            end
            IN_START:
            begin
                open_next     = 1'b1;
                state_next    = PS_IDLE;
                step_next     = '0;
                hb_left_next  = reload_reg;
                awaiting_next = 1'b1;
                up_next       = 1'b0;
                job_valid     = 1'b1;
                job.kind      = JOB_HAND;
            end
            default:
            begin
                if (open_reg && !up_reg)
                begin
                    open_next  = 1'b0;
                    job_valid  = 1'b1;
                    job.kind   = JOB_DISC;
                    job.word_a = 32'd1;
                end
            end
        endcase
    end

    // control and link registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= PS_IDLE;
            step_reg     <= '0;
            hb_left_reg  <= RESET_RELOAD;
            awaiting_reg <= 1'b1;
            up_reg       <= 1'b0;
            open_reg     <= 1'b0;
            baud_reg     <= RESET_BAUD;
            reload_reg   <= RESET_RELOAD;
            stamp_reg    <= '0;
            ident_reg    <= '0;
            ident_raw_reg <= '0;
            ext_reg      <= 1'b0;
            fbus_reg     <= '0;
            flen_reg     <= '0;
            bus0_reg     <= '0;
            bus1_reg     <= '0;
            en_reg       <= '0;
            build_reg    <= '0;
            for (int i = 0; i < 8; i++)
                bytes_reg[i] <= '0;
        end
        else
        begin
            if (accept)
            begin
                state_reg     <= state_next;
                step_reg      <= step_next;
                hb_left_reg   <= hb_left_next;
                awaiting_reg  <= awaiting_next;
                up_reg        <= up_next;
                open_reg      <= open_next;
                stamp_reg     <= stamp_next;
                ident_reg     <= ident_next;
                ident_raw_reg <= ident_raw_next;
                ext_reg       <= ext_next;
                fbus_reg      <= fbus_next;
                flen_reg      <= flen_next;
                bus0_reg      <= bus0_next;
                bus1_reg      <= bus1_next;
                en_reg        <= en_next;
                build_reg     <= build_next;
                bytes_reg     <= bytes_next;
            end
            if (cfg_we)
            begin
                if (cfg_index == CFG_FALLBACK_BAUD)
                    baud_reg <= cfg_data;
                else
                    reload_reg <= cfg_data[7:0];
            end
        end
    end

endmodule

### src/cblp_queue.sv
// ----------------------------------------------------------------------------
// cblp_queue
// Short job queue that decouples the front classifier from the back emitter.
// ----------------------------------------------------------------------------
module cblp_queue
    import cblp_pkg::*;
(
    input  logic clk,
    input  logic rst_n,
    input  logic push,
    input  job_t push_job,
    output logic full,
    input  logic pop,
    output logic head_valid,
    output job_t head_job
);

    localparam int PW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int CW = $clog2(QUEUE_DEPTH + 1);

    job_t          mem [QUEUE_DEPTH];
    logic [PW-1:0] wr_ptr_reg, rd_ptr_reg;
    logic [CW-1:0] count_reg, count_next;

    assign full       = (count_reg == CW'(QUEUE_DEPTH));
    assign head_valid = (count_reg != '0);
    assign head_job   = mem[rd_ptr_reg];
    assign count_next = count_reg + CW'(push) - CW'(pop);

    // storage
    always_ff @(posedge clk)
    begin
        if (push)
            mem[wr_ptr_reg] <= push_job;
    end

    // pointers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (push)
                wr_ptr_reg <= (wr_ptr_reg == PW'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
            if (pop)
                rd_ptr_reg <= (rd_ptr_reg == PW'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
            count_reg <= count_next;
        end
    end

endmodule

### src/cblp_back.sv
// ----------------------------------------------------------------------------
// cblp_back
// Expands each queued job into its event words, one per cycle while the
// receiver is ready, through an output register.
// ----------------------------------------------------------------------------
module cblp_back
    import cblp_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        head_valid,
    input  job_t        head_job,
    output logic        pop,
    output logic        out_valid,
    input  logic        out_ready,
    output logic [2:0]  event_kind,
    output logic [31:0] stamp,
    output logic [30:0] frame_id,
    output logic        is_extended,
    output logic [3:0]  bus_number,
    output logic [3:0]  payload_len,
    output logic [63:0] payload,
    output logic [31:0] word_a,
    output logic [31:0] word_b,
    output logic [1:0]  enable_bits,
    output logic [7:0]  tx_byte,
    output logic        last
);

    logic [3:0]  idx_reg, idx_next;
    logic        valid_reg;
    logic        load;
    logic [3:0]  final_idx;
    logic [2:0]  r_kind;
    logic [7:0]  r_tx;
    logic        r_last;
    logic [2:0]  kind_reg;
    logic [31:0] stamp_reg, wa_reg, wb_reg;
    logic [30:0] id_reg;
    logic        ext_reg, last_reg;
    logic [3:0]  bus_reg, len_reg;
    logic [63:0] pl_reg;
    logic [1:0]  en_reg;
    logic [7:0]  tx_reg;

    assign load = head_valid && (!valid_reg || out_ready);
    assign pop  = load && r_last;

    // word selection for the current job and step
    always_comb
    begin
        final_idx = 4'd0;
        r_kind    = EV_TX;
        r_tx      = 8'd0;
        case (head_job.kind)
            JOB_FRAME: r_kind = EV_FRAME;
            JOB_INFO:  r_kind = EV_INFO;
            JOB_DISC:  r_kind = EV_DISC;
            JOB_NBUS, JOB_HEART:
            begin
                final_idx = 4'd1;
                if (idx_reg == 4'd0)
                    r_tx = MARK;
                else
                    r_tx = (head_job.kind == JOB_NBUS) ? CMD_EXTBUS : CMD_VALIDATE;
            end
            JOB_HAND:
            begin
                final_idx = 4'd11;
                r_tx      = hand_byte(idx_reg);
            end
            JOB_PARAMS:
            begin
                final_idx = head_job.conn ? 4'd12 : 4'd11;
                case (idx_reg)
                    4'd0:    r_kind = EV_PARAMS;
                    4'd1:    r_tx = MARK;
                    4'd2:    r_tx = CMD_SETUP;
                    4'd3:    r_tx = head_job.setup_word[7:0];
                    4'd4:    r_tx = head_job.setup_word[15:8];
                    4'd5:    r_tx = head_job.setup_word[23:16];
                    4'd6:    r_tx = head_job.setup_word[31:24];
                    4'd12:   r_kind = EV_CONN;
                    default: r_tx = 8'd0;
                endcase
            end
            default: r_kind = EV_DISC;
        endcase
        r_last   = (idx_reg == final_idx);
        idx_next = r_last ? 4'd0 : idx_reg + 4'd1;
    end

    // step counter and output valid
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            idx_reg   <= '0;
            valid_reg <= 1'b0;
        end
        else
        begin
            if (load)
                idx_reg <= idx_next;
            if (load)
                valid_reg <= 1'b1;
            else if (out_ready)
                valid_reg <= 1'b0;
        end
    end

    // output word register
    always_ff @(posedge clk)
    begin
        if (load)
        begin
            kind_reg  <= r_kind;
            tx_reg    <= r_tx;
            last_reg  <= r_last;
            stamp_reg <= (r_kind == EV_FRAME) ? head_job.stamp : '0;
            id_reg    <= (r_kind == EV_FRAME) ? head_job.ident : '0;
            ext_reg   <= (r_kind == EV_FRAME) ? head_job.ext : 1'b0;
            bus_reg   <= (r_kind == EV_FRAME) ? head_job.bus : '0;
            len_reg   <= (r_kind == EV_FRAME) ? head_job.len : '0;
            pl_reg    <= (r_kind == EV_FRAME) ? head_job.payload : '0;
            wa_reg    <= (r_kind == EV_PARAMS || r_kind == EV_INFO || r_kind == EV_DISC)
                         ? head_job.word_a : '0;
            wb_reg    <= (r_kind == EV_PARAMS || r_kind == EV_INFO) ? head_job.word_b : '0;
            en_reg    <= (r_kind == EV_PARAMS) ? head_job.enables : '0;
        end
    end

    assign out_valid   = valid_reg;
    assign event_kind  = kind_reg;
    assign stamp       = stamp_reg;
    assign frame_id    = id_reg;
    assign is_extended = ext_reg;
    assign bus_number  = bus_reg;
    assign payload_len = len_reg;
    assign payload     = pl_reg;
    assign word_a      = wa_reg;
    assign word_b      = wb_reg;
    assign enable_bits = en_reg;
    assign tx_byte     = tx_reg;
    assign last        = last_reg;

    // a job in mid-expansion stays at the queue head
    a_mid_job_held: assert property (@(posedge clk) disable iff (!rst_n)
        (idx_reg != 4'd0) |-> head_valid)
        else $error("step counter running without a queued job");

    // connected event always closes its job
    a_conn_last: assert property (@(posedge clk) disable iff (!rst_n)
        (valid_reg && kind_reg == EV_CONN) |-> last_reg)
        else $error("connected event not marked last");

    // the step counter returns to zero exactly when a job is retired
    a_pop_resets: assert property (@(posedge clk) disable iff (!rst_n)
        pop |=> (idx_reg == 4'd0))
        else $error("step counter not cleared after job retired");

endmodule

### src/can_bridge_link_parser_core.sv
// ----------------------------------------------------------------------------
// can_bridge_link_parser_core
// Host side deframer and link controller for a binary CAN bridge serial link.
// ----------------------------------------------------------------------------
// Input channel (in_valid/in_ready, command, rx_byte): one word per session
// start, heartbeat tick, connect timeout or received byte. The front takes
// one word per cycle whenever its job queue has room.
// Output channel (out_valid/out_ready): event words in order; the word marked
// last closes the events of one input word. Words that cause no event leave
// nothing on the output.
// The back emits one event word per cycle, while out_ready is high, from the
// queue head; a job passes through a queue entry and then the output register.
// A session start yields 12 words, a bus parameter reply 12 or 13, a heartbeat
// or bus-list reply 2 (1 if it closes the link) and any other event input 1.
// When the receiver stalls the output register holds, the two-entry queue
// fills and in_ready drops.
// Reset clears the link to closed, parser idle, fallback rate 500000 and a
// heartbeat budget of 10 ticks. cfg_we writes register cfg_index at once.
// ----------------------------------------------------------------------------
module can_bridge_link_parser_core
    import cblp_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_ready,
    input  logic [1:0]  command,
    input  logic [7:0]  rx_byte,
    input  logic        cfg_we,
    input  logic        cfg_index,
    input  logic [31:0] cfg_data,
    output logic        out_valid,
    input  logic        out_ready,
    output logic [2:0]  event_kind,
    output logic [31:0] stamp,
    output logic [30:0] frame_id,
    output logic        is_extended,
    output logic [3:0]  bus_number,
    output logic [3:0]  payload_len,
    output logic [63:0] payload,
    output logic [31:0] word_a,
    output logic [31:0] word_b,
    output logic [1:0]  enable_bits,
    output logic [7:0]  tx_byte,
    output logic        last
);

    logic push, q_full, pop, head_valid;
    job_t push_job, head_job;

    // classifier
    cblp_front u_front (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_ready (in_ready),
        .command  (command),
        .rx_byte  (rx_byte),
        .cfg_we   (cfg_we),
        .cfg_index(cfg_index),
        .cfg_data (cfg_data),
        .q_full   (q_full),
        .push     (push),
        .push_job (push_job)
    );

    // job queue
    cblp_queue u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .push_job  (push_job),
        .full      (q_full),
        .pop       (pop),
        .head_valid(head_valid),
        .head_job  (head_job)
    );

    // event emitter
    cblp_back u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .head_valid (head_valid),
        .head_job   (head_job),
        .pop        (pop),
        .out_valid  (out_valid),
        .out_ready  (out_ready),
        .event_kind (event_kind),
        .stamp      (stamp),
        .frame_id   (frame_id),
        .is_extended(is_extended),
        .bus_number (bus_number),
        .payload_len(payload_len),
        .payload    (payload),
        .word_a     (word_a),
        .word_b     (word_b),
        .enable_bits(enable_bits),
        .tx_byte    (tx_byte),
        .last       (last)
    );

endmodule
